[src/bca_pkg.sv]
// Shared types and operation codes for the BCD-capable 8-bit ALU.
`default_nettype none
package bca_pkg;

    localparam logic [3:0] FN_ADC = 4'd0;
    localparam logic [3:0] FN_SBC = 4'd1;
    localparam logic [3:0] FN_AND = 4'd2;
    localparam logic [3:0] FN_ORA = 4'd3;
    localparam logic [3:0] FN_EOR = 4'd4;
    localparam logic [3:0] FN_ASL = 4'd5;
    localparam logic [3:0] FN_LSR = 4'd6;
    localparam logic [3:0] FN_ROL = 4'd7;
    localparam logic [3:0] FN_ROR = 4'd8;
    localparam logic [3:0] FN_INC = 4'd9;
    localparam logic [3:0] FN_DEC = 4'd10;
    localparam logic [3:0] FN_CMP = 4'd11;
    localparam logic [3:0] FN_BIT = 4'd12;

    // BCD correction constants
    localparam logic [9:0] BCD_NIB_ADJ = 10'h006;
    localparam logic [9:0] BCD_HI_ADJ  = 10'h060;
    localparam logic [9:0] BCD_MAX     = 10'h099;
    localparam logic [4:0] BCD_DIGIT   = 5'd9;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] reg_value;
        logic [7:0] operand;
        logic       carry_in;
        logic       decimal_in;
        logic       overflow_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic       negative_out;
        logic       zero_out;
        logic       carry_out;
        logic       overflow_out;
    } t_alu_out;

    // Per-stage beat: w is the 10-bit working sum (wraps like the 16-bit form
    // in every bit that matters); res/c hold final values for non-arith ops.
    typedef struct packed {
        logic       valid;
        logic       arith;
        logic       dec_add;
        logic       dec_sub;
        logic       nib;
        logic [9:0] w;
        logic [7:0] res;
        logic       n;
        logic       z;
        logic       c;
        logic       v;
    } t_stage;

endpackage
`default_nettype wire

[src/bca_front.sv]
// Stage 1: operation decode, binary adder, logic and shift unit, flags.
`default_nettype none
module bca_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  bca_pkg::t_alu_in i_in,
    output bca_pkg::t_stage  o_stage
);
    import bca_pkg::*;

    t_stage     r_stage;
    t_stage     n_stage;
    logic [7:0] acc;
    logic [7:0] mem;
    logic [7:0] b;
    logic [8:0] sum9;
    logic [9:0] diff10;
    logic [8:0] cmp9;
    logic [4:0] lo_add;
    logic [4:0] lo_a;
    logic [4:0] lo_m;

    assign acc    = i_in.reg_value;
    assign mem    = i_in.operand;
    assign b      = (i_in.func == FN_SBC) ? ~mem : mem;
    assign sum9   = {1'b0, acc} + {1'b0, b} + {8'd0, i_in.carry_in};
    assign diff10 = {2'b00, acc} - {2'b00, mem} - {9'd0, ~i_in.carry_in};
    assign cmp9   = {1'b0, acc} - {1'b0, mem};
    assign lo_add = {1'b0, acc[3:0]} + {1'b0, mem[3:0]} + {4'd0, i_in.carry_in};
    assign lo_a   = {1'b0, acc[3:0]} + {4'd0, i_in.carry_in};
    assign lo_m   = {1'b0, mem[3:0]} + 5'd1;

    always_comb begin
        n_stage         = '0;
        n_stage.valid   = i_valid;
        n_stage.res     = acc;
        n_stage.c       = i_in.carry_in;
        n_stage.v       = i_in.overflow_in;
        case (i_in.func)
            FN_ADC, FN_SBC: begin
                n_stage.arith = 1'b1;
                n_stage.n     = sum9[7];
                n_stage.z     = (sum9[7:0] == 8'd0);
                if (i_in.func == FN_SBC && i_in.decimal_in) begin
                    // decimal subtract: signed working value, subtract-form V
                    n_stage.dec_sub = 1'b1;
                    n_stage.w       = diff10;
                    n_stage.nib     = (lo_a < lo_m);
                    n_stage.v       = ((acc[7] ^ mem[7]) & (acc[7] ^ sum9[7]));
                end else begin
                    n_stage.dec_add = (i_in.func == FN_ADC) && i_in.decimal_in;
                    n_stage.w       = {1'b0, sum9};
                    n_stage.nib     = n_stage.dec_add && (lo_add > BCD_DIGIT);
                    n_stage.v       = ((acc[7] ^ sum9[7]) & (b[7] ^ sum9[7]));
                end
            end
            FN_AND: n_stage.res = acc & mem;
            FN_ORA: n_stage.res = acc | mem;
            FN_EOR: n_stage.res = acc ^ mem;
            FN_ASL: begin
                n_stage.res = {mem[6:0], 1'b0};
                n_stage.c   = mem[7];
            end
            FN_LSR: begin
                n_stage.res = {1'b0, mem[7:1]};
                n_stage.c   = mem[0];
            end
            FN_ROL: begin
                n_stage.res = {mem[6:0], i_in.carry_in};
                n_stage.c   = mem[7];
            end
            FN_ROR: begin
                n_stage.res = {i_in.carry_in, mem[7:1]};
                n_stage.c   = mem[0];
            end
            FN_INC: n_stage.res = mem + 8'd1;
            FN_DEC: n_stage.res = mem - 8'd1;
            default: n_stage.res = acc;
        endcase

        // flags for the non-arithmetic ops
        if (!n_stage.arith) begin
            n_stage.n = n_stage.res[7];
            n_stage.z = (n_stage.res == 8'd0);
        end
        if (i_in.func == FN_CMP) begin
            n_stage.c = ~cmp9[8];
            n_stage.n = cmp9[7];
            n_stage.z = (cmp9[7:0] == 8'd0);
        end
        if (i_in.func == FN_BIT) begin
            n_stage.n = mem[7];
            n_stage.v = mem[6];
            n_stage.z = ((acc & mem) == 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule
`default_nettype wire

[src/bca_nib_fix.sv]
// Stage 2: low-digit BCD correction.
`default_nettype none
module bca_nib_fix (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  bca_pkg::t_stage i_stage,
    output bca_pkg::t_stage o_stage
);
    import bca_pkg::*;

    t_stage r_stage;
    t_stage n_stage;

    always_comb begin
        n_stage = i_stage;
        if (i_stage.nib) begin
            n_stage.w = i_stage.dec_sub ? (i_stage.w - BCD_NIB_ADJ)
                                        : (i_stage.w + BCD_NIB_ADJ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule
`default_nettype wire

[src/bca_hi_fix.sv]
// Stage 3: high-digit BCD correction, carry select and output register.
`default_nettype none
module bca_hi_fix (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  bca_pkg::t_stage   i_stage,
    output logic              o_valid,
    output bca_pkg::t_alu_out o_out
);
    import bca_pkg::*;

    logic       r_valid;
    t_alu_out   r_out;
    t_alu_out   n_out;
    logic       hi;
    logic [9:0] wf;

    // negative working values are above the limit as unsigned, as wanted
    assign hi = (i_stage.dec_add || i_stage.dec_sub) && (i_stage.w > BCD_MAX);

    always_comb begin
        wf = i_stage.w;
        if (hi) begin
            wf = i_stage.dec_sub ? (i_stage.w - BCD_HI_ADJ) : (i_stage.w + BCD_HI_ADJ);
        end
        n_out.negative_out = i_stage.n;
        n_out.zero_out     = i_stage.z;
        n_out.overflow_out = i_stage.v;
        if (i_stage.arith) begin
            n_out.result    = wf[7:0];
            n_out.carry_out = i_stage.dec_sub ? ~wf[8] : wf[8];
        end else begin
            n_out.result    = i_stage.res;
            n_out.carry_out = i_stage.c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule
`default_nettype wire

[src/bcd_capable_8bit_alu.sv]
// Top level of the three-stage BCD-capable 8-bit ALU.
//
//  channel | direction | handshake        | beat
//  --------+-----------+------------------+----------------------------------
//  command | in        | start, busy      | i_in  : func, reg_value, operand,
//          |           |                  |         carry_in, decimal_in,
//          |           |                  |         overflow_in
//  result  | out       | o_strobe         | o_out : result, N, Z, C, V flags
//
// An accepted start reaches o_strobe through the three register stages (decode and
// binary adder, low-digit correction, high-digit correction and carry select);
// one beat per cycle is sustained.
// busy is always low, so a command is taken in every cycle start is high.
// Synchronous active-low reset clears the first two stage registers and the
// output valid bit; the output beat register is left as is.
// Results show for one cycle; the receiver cannot hold them off.
`default_nettype none
module bcd_capable_8bit_alu (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  bca_pkg::t_alu_in   i_in,
    output logic               o_strobe,
    output bca_pkg::t_alu_out  o_out
);
    import bca_pkg::*;

    t_stage s1;
    t_stage s2;
    logic   accept;

    // Pipeline never stalls: no output backpressure exists.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage 1: decode, binary sum/difference, logic and shifts, N/Z/V.
    bca_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_in    (i_in),
        .o_stage (s1)
    );

    // Stage 2: +/-6 on the low digit for decimal ADC/SBC.
    bca_nib_fix u_nib (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (s1),
        .o_stage (s2)
    );

    // Stage 3: +/-0x60 on the high digit, carry from bit 8, result register.
    bca_hi_fix u_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (s2),
        .o_valid (o_strobe),
        .o_out   (o_out)
    );

    // Every accepted command yields a strobe after passing through all the stage registers.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_strobe)
        else $error("accepted command produced no strobe");

    // No strobe without an earlier accepted command.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 3))
        else $error("strobe without a command");

    // Compare returns the register value unchanged.
    a_cmp_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.func == FN_CMP) |-> ##3
            (o_out.result == $past(i_in.reg_value, 3)))
        else $error("compare altered the register value");

endmodule
`default_nettype wire

[test/tb_bcd_capable_8bit_alu.sv]
// Self-checking testbench for the BCD-capable 8-bit ALU: directed corners, then random beats.
`timescale 1ns / 100ps

module tb_bcd_capable_8bit_alu;
    import bca_pkg::*;

    // Selector codes past FN_BIT; the block passes reg_value through for these.
    localparam logic [3:0] FN_PASS_FIRST = 4'd13;
    localparam logic [3:0] FN_PASS_LAST  = 4'd15;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 64;   // cycles allowed for the pipe to empty at the end

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_alu_in  i_in    = '0;
    logic     busy;
    logic     o_strobe;
    t_alu_out o_out;

    // Flag/result beats predicted at command acceptance, oldest first.
    t_alu_out alu_expected_q[$];
    int       fail_count = 0;
    int       idle_pct   = 0;     // chance per cycle that the sender holds start low

    bcd_capable_8bit_alu uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor. Decimal ADC/SBC take N, Z and V from the binary sum and
    // only then apply the digit corrections in 16-bit wrap arithmetic,
    // as the NMOS part does. Decimal SBC uses the subtraction V formula.
    // ------------------------------------------------------------------
    function automatic t_alu_out alu_predict(input t_alu_in beat);
        t_alu_out    flags;
        logic [7:0]  acc;
        logic [7:0]  mem;
        logic [7:0]  addend;
        logic [7:0]  res;
        logic        cin;
        logic        n;
        logic        z;
        logic        c;
        logic        v;
        logic        nz_done;
        int unsigned w;

        acc     = beat.reg_value;
        mem     = beat.operand;
        cin     = beat.carry_in;
        res     = acc;
        c       = cin;
        v       = beat.overflow_in;
        n       = 1'b0;
        z       = 1'b0;
        nz_done = 1'b0;

        case (beat.func)
            FN_ADC, FN_SBC: begin
                nz_done = 1'b1;
                if (beat.func == FN_SBC && beat.decimal_in) begin
                    w   = (acc - mem - (cin ^ 1'b1)) & 'hFFFF;
                    res = w[7:0];
                    n   = res[7];
                    z   = (res == 8'h00);
                    v   = (acc[7] ^ mem[7]) & (acc[7] ^ res[7]);
                    // low digit borrowed: pull the low nibble back into 0..9
                    if (acc[3:0] + cin < mem[3:0] + 1)
                        w = (w - 6) & 'hFFFF;
                    if (w > 'h99)
                        w = (w - 'h60) & 'hFFFF;
                    c   = ~w[8];
                    res = w[7:0];
                end else begin
                    // binary SBC is ADC of the inverted operand
                    addend = (beat.func == FN_SBC) ? ~mem : mem;
                    w      = acc + addend + cin;
                    res    = w[7:0];
                    n      = res[7];
                    z      = (res == 8'h00);
                    v      = (acc[7] ^ res[7]) & (addend[7] ^ res[7]);
                    if (beat.func == FN_ADC && beat.decimal_in) begin
                        if (acc[3:0] + addend[3:0] + cin > 9)
                            w = w + 6;
                        if (w > 'h99)
                            w = w + 96;
                        w = w & 'hFFFF;
                    end
                    c   = w[8];
                    res = w[7:0];
                end
            end
            FN_AND: res = acc & mem;
            FN_ORA: res = acc | mem;
            FN_EOR: res = acc ^ mem;
            FN_ASL: begin
                c   = mem[7];
                res = {mem[6:0], 1'b0};
            end
            FN_LSR: begin
                c   = mem[0];
                res = {1'b0, mem[7:1]};
            end
            FN_ROL: begin
                c   = mem[7];
                res = {mem[6:0], cin};
            end
            FN_ROR: begin
                c   = mem[0];
                res = {cin, mem[7:1]};
            end
            FN_INC: res = mem + 8'd1;
            FN_DEC: res = mem - 8'd1;
            FN_CMP: begin
                w       = (acc - mem) & 'hFFFF;
                c       = ~w[8];
                n       = w[7];
                z       = (w[7:0] == 8'h00);
                nz_done = 1'b1;
            end
            FN_BIT: begin
                n       = mem[7];
                v       = mem[6];
                z       = ((acc & mem) == 8'h00);
                nz_done = 1'b1;
            end
            default: res = acc;
        endcase

        if (!nz_done) begin
            n = res[7];
            z = (res == 8'h00);
        end
        flags.result       = res;
        flags.negative_out = n;
        flags.zero_out     = z;
        flags.carry_out    = c;
        flags.overflow_out = v;
        return flags;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard. A command is taken at the edge where start is high and
    // busy low; its prediction is queued there. Every strobed beat is
    // matched against the oldest prediction. Values are read at the edge,
    // before any of this step's nonblocking updates land.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_alu_out want;
        if (i_rst_n) begin
            if (start && busy === 1'b0)
                alu_expected_q.push_back(alu_predict(i_in));
            if (o_strobe !== 1'b0) begin
                if (alu_expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result res=%h NZCV=%b%b%b%b",
                                 $time, o_out.result, o_out.negative_out, o_out.zero_out,
                                 o_out.carry_out, o_out.overflow_out);
                end else begin
                    want = alu_expected_q.pop_front();
                    if (o_out.result       !== want.result       ||
                        o_out.negative_out !== want.negative_out ||
                        o_out.zero_out     !== want.zero_out     ||
                        o_out.carry_out    !== want.carry_out    ||
                        o_out.overflow_out !== want.overflow_out) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: exp res=%h NZCV=%b%b%b%b got res=%h NZCV=%b%b%b%b",
                                     $time, want.result, want.negative_out, want.zero_out,
                                     want.carry_out, want.overflow_out, o_out.result,
                                     o_out.negative_out, o_out.zero_out, o_out.carry_out,
                                     o_out.overflow_out);
                    end
                end
            end
        end
    end

    // Present one command beat, with random idle cycles ahead of it, and
    // return at the edge that accepts it. start stays high afterwards so
    // back-to-back beats never drop it in between.
    task automatic send_beat(input t_alu_in beat);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= beat;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic send_op(input logic [3:0] func, input logic [7:0] acc,
                           input logic [7:0] mem, input logic cin,
                           input logic dec, input logic vin);
        t_alu_in beat;
        beat.func        = func;
        beat.reg_value   = acc;
        beat.operand     = mem;
        beat.carry_in    = cin;
        beat.decimal_in  = dec;
        beat.overflow_in = vin;
        send_beat(beat);
    endtask

    // Carry/zero/overflow edges of binary and decimal add and subtract.
    task automatic test_arith_corners();
        send_op(FN_ADC, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);   // zero, V cleared
        send_op(FN_ADC, 8'hFF, 8'h01, 1'b0, 1'b0, 1'b0);   // wrap to zero, carry out
        send_op(FN_ADC, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b0);   // signed overflow
        send_op(FN_ADC, 8'h99, 8'h01, 1'b0, 1'b1, 1'b0);   // decimal 99+1 carries
        send_op(FN_ADC, 8'h58, 8'h46, 1'b1, 1'b1, 1'b0);   // both digit corrections
        send_op(FN_ADC, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);   // non-BCD digits
        send_op(FN_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0);   // binary overflow
        send_op(FN_SBC, 8'h00, 8'h01, 1'b1, 1'b1, 1'b0);   // decimal borrow to 99
        send_op(FN_SBC, 8'h46, 8'h12, 1'b0, 1'b1, 1'b1);   // decimal with borrow in
        send_op(FN_SBC, 8'h80, 8'h01, 1'b1, 1'b1, 1'b0);   // decimal subtraction overflow
        send_op(FN_SBC, 8'h0A, 8'hFF, 1'b0, 1'b1, 1'b1);   // non-BCD digits
    endtask

    // Logic ops, shifts, rotates and counts at the byte extremes.
    task automatic test_logic_shift_corners();
        send_op(FN_AND, 8'hFF, 8'hAA, 1'b1, 1'b1, 1'b1);
        send_op(FN_ORA, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_op(FN_EOR, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1);
        send_op(FN_ASL, 8'h00, 8'h80, 1'b0, 1'b1, 1'b0);
        send_op(FN_LSR, 8'hFF, 8'h01, 1'b0, 1'b0, 1'b1);
        send_op(FN_ROL, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0);
        send_op(FN_ROR, 8'h00, 8'h01, 1'b1, 1'b1, 1'b1);
        send_op(FN_INC, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
        send_op(FN_DEC, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1);
    endtask

    // Compare orderings, BIT flag sourcing and the pass-through selectors.
    task automatic test_compare_bit_unused();
        send_op(FN_CMP, 8'h40, 8'h40, 1'b0, 1'b0, 1'b1);   // equal: Z and C
        send_op(FN_CMP, 8'h10, 8'h20, 1'b1, 1'b0, 1'b0);   // less: borrow
        send_op(FN_BIT, 8'h0F, 8'hC0, 1'b1, 1'b1, 1'b0);   // N, V from operand, Z set
        send_op(FN_PASS_FIRST, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_op(FN_PASS_LAST,  8'h80, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // Random beats. Close to half are add/subtract, largely in decimal mode with
    // valid BCD digits, since that is where the corrections live.
    task automatic run_random(input int count);
        t_alu_in beat;
        repeat (count) begin
            beat.reg_value   = 8'($urandom_range(255));
            beat.operand     = 8'($urandom_range(255));
            beat.carry_in    = 1'($urandom_range(1));
            beat.decimal_in  = 1'($urandom_range(1));
            beat.overflow_in = 1'($urandom_range(1));
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    beat.func       = $urandom_range(1) ? FN_SBC : FN_ADC;
                    beat.decimal_in = ($urandom_range(3) != 0);
                    if ($urandom_range(3) != 0) begin
                        beat.reg_value = 8'($urandom_range(9) * 16 + $urandom_range(9));
                        beat.operand   = 8'($urandom_range(9) * 16 + $urandom_range(9));
                    end
                end
                19:      beat.func = 4'($urandom_range(FN_PASS_FIRST, FN_PASS_LAST));
                default: beat.func = 4'($urandom_range(FN_AND, FN_BIT));
            endcase
            send_beat(beat);
        end
    endtask

    task automatic test_random_back_to_back();
        idle_pct = 0;
        run_random(300);
    endtask

    task automatic test_random_sparse_sender();
        idle_pct = 71;
        run_random(250);
    endtask

    task automatic test_random_light_gaps();
        idle_pct = 15;
        run_random(250);
    endtask

    // Main sequence: reset, directed corners, three random phases, drain.
    initial begin
        int drain;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_arith_corners();
        test_logic_shift_corners();
        idle_pct = 40;
        test_compare_bit_unused();
        test_random_back_to_back();
        test_random_sparse_sender();
        test_random_light_gaps();

        start <= 1'b0;
        drain = 0;
        while (alu_expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (6) @(posedge i_clk);
        // anything still queued never came back
        fail_count += alu_expected_q.size();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: the full run takes well under a tenth of this.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
src/bca_pkg.sv
src/bca_front.sv
src/bca_nib_fix.sv
src/bca_hi_fix.sv
src/bcd_capable_8bit_alu.sv
test/tb_bcd_capable_8bit_alu.sv
